>>> design/svf_pkg.sv
// Types and constants shared by the state variable bandpass filter.
package svf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 24;
    localparam int STATE_W  = 32;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Datapath widths.
    localparam int GX_W   = COEF_W + 1 + SAMPLE_W;
    localparam int PROD_W = COEF_W + 1 + STATE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int T_W    = SUM_W - COEF_W;
    localparam int ACC_W  = T_W + 2;

    localparam logic [COEF_W-1:0] GAIN_ONE_RST = 24'd4194304;
    localparam logic [COEF_W-1:0] DAMP_ONE_RST = 24'd4194304;
    localparam logic [COEF_W-1:0] GAIN_TWO_RST = 24'd2097152;

    typedef enum logic [1:0] {
        REG_GAIN_ONE = 2'd0,
        REG_DAMP_ONE = 2'd1,
        REG_GAIN_TWO = 2'd2
    } svf_reg_t;

    typedef struct packed {
        logic                       channel;
        logic signed [SAMPLE_W-1:0] sample_in;
    } svf_in_t;

    typedef struct packed {
        logic                       channel_out;
        logic signed [SAMPLE_W-1:0] bandpass_out;
    } svf_out_t;

endpackage

>>> design/svf_bandpass_filter.sv
// State variable bandpass filter: per-channel integrator memory and three-stage datapath.
//
//   channel | ports                                   | beat
//   --------+-----------------------------------------+-------------------------------
//   input   | s_valid, s_ready, s_data                | channel, sample_in
//   output  | m_valid, m_ready, m_data                | channel_out, bandpass_out
//   config  | psel, penable, pwrite, paddr, pwdata... | coefficient, 0x0 / 0x4 / 0x8
//
// A beat passes through stage 1, stage 2 and the output register. Beats on different channels
// go in every cycle unless the output stalls; a beat on the channel stage 2 still updates waits
// in stage 1, set by the integrator read-modify-write loop (multiply stage, then sum stage).
// Reset is synchronous; the integrator memory reads as zero until a channel is first written.
// The output register decouples the sides, so input beats are taken while a result waits
// as long as a pipeline stage is free.
module svf_bandpass_filter #(
    parameter int CHANNELS = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  svf_pkg::svf_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output svf_pkg::svf_out_t               m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [svf_pkg::PADDR_W-1:0]     paddr,
    input  logic [svf_pkg::PDATA_W-1:0]     pwdata,
    output logic [svf_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import svf_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (COEF_W - 1));
    localparam logic signed [ACC_W-1:0] ST_MAX  = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] ST_MIN  = ACC_W'(32'sh8000_0000);
    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(64'sd1 <<< (SAMPLE_W - 1)));

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        priority if (v > ST_MAX) c = ST_MAX;
        else if (v < ST_MIN)     c = ST_MIN;
        else                     c = v;
        return c[STATE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        priority if (v > OUT_MAX) c = OUT_MAX;
        else if (v < OUT_MIN)     c = OUT_MIN;
        else                      c = v;
        return c[SAMPLE_W-1:0];
    endfunction

    // Coefficient registers
    logic [COEF_W-1:0] gain_one_reg;
    logic [COEF_W-1:0] damp_one_reg;
    logic [COEF_W-1:0] gain_two_reg;
    logic [1:0]        reg_idx;
    logic              cfg_wr;

    // Integrator memory: {first, second} per channel
    logic [2*STATE_W-1:0] mem [CHANNELS];
    logic [CHANNELS-1:0]  live_reg;
    logic [2*STATE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 wr_en;
    logic                 accept;
    logic                 s_in_range;

    // Last write, for a read that raced it
    logic signed [STATE_W-1:0] byp_int1_reg;
    logic signed [STATE_W-1:0] byp_int2_reg;

    // Stage 1: memory data arrives, state products
    logic                      p1_valid_reg;
    logic                      p1_ch_reg;
    logic                      p1_inr_reg;
    logic                      p1_live_reg;
    logic                      p1_fwd_reg;
    logic                      p1_fwd_next;
    logic signed [GX_W-1:0]    p1_gx1_reg;
    logic signed [GX_W-1:0]    p1_gx2_reg;
    logic signed [STATE_W-1:0] p1_int1;
    logic signed [STATE_W-1:0] p1_int2;
    logic                      p1_adv;

    // Stage 2: sums, rounding, saturation, write back
    logic                      p2_valid_reg;
    logic                      p2_ch_reg;
    logic                      p2_inr_reg;
    logic signed [STATE_W-1:0] p2_int1_reg;
    logic signed [STATE_W-1:0] p2_int2_reg;
    logic signed [GX_W-1:0]    p2_gx1_reg;
    logic signed [GX_W-1:0]    p2_gx2_reg;
    logic signed [PROD_W-1:0]  p2_g1i2_reg;
    logic signed [PROD_W-1:0]  p2_d1i1_reg;
    logic signed [PROD_W-1:0]  p2_g2i2_reg;
    logic signed [PROD_W-1:0]  p2_g1i1_reg;
    logic                      p2_ready;
    logic signed [SUM_W-1:0]   sum1;
    logic signed [SUM_W-1:0]   sum2;
    logic signed [T_W-1:0]     t1;
    logic signed [T_W-1:0]     t2;
    logic signed [ACC_W-1:0]   acc1;
    logic signed [ACC_W-1:0]   acc2;
    logic signed [ACC_W-1:0]   bp_acc;
    logic signed [STATE_W-1:0] new_int1;
    logic signed [STATE_W-1:0] new_int2;

    // Output register
    logic     m_valid_reg;
    svf_out_t m_data_reg;
    logic     out_ready;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_GAIN_ONE: prdata = PDATA_W'(gain_one_reg);
            REG_DAMP_ONE: prdata = PDATA_W'(damp_one_reg);
            REG_GAIN_TWO: prdata = PDATA_W'(gain_two_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_one_reg <= GAIN_ONE_RST;
            damp_one_reg <= DAMP_ONE_RST;
            gain_two_reg <= GAIN_TWO_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GAIN_ONE: gain_one_reg <= pwdata[COEF_W-1:0];
                REG_DAMP_ONE: damp_one_reg <= pwdata[COEF_W-1:0];
                REG_GAIN_TWO: gain_two_reg <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_ready = !m_valid_reg || m_ready;
    assign p2_ready  = !p2_valid_reg || out_ready;
    // Hold stage 1 while stage 2 still owes the same channel its write back
    assign p1_adv    = p1_valid_reg && p2_ready &&
                       !(p2_valid_reg && p2_inr_reg && (p2_ch_reg == p1_ch_reg));
    assign s_ready   = !p1_valid_reg || p1_adv;
    assign accept    = s_valid && s_ready;

    assign s_in_range = 32'(s_data.channel) < CHANNELS;
    assign rd_addr    = s_in_range ? ADDR_W'(s_data.channel) : '0;
    assign wr_addr    = ADDR_W'(p2_ch_reg);
    assign wr_en      = p2_valid_reg && out_ready && p2_inr_reg;

    // ---------------- memory ----------------
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {new_int1, new_int2};
        end
        if (accept) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
        end else if (wr_en) begin
            live_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            byp_int1_reg <= new_int1;
            byp_int2_reg <= new_int2;
        end
    end

    // ---------------- stage 1 ----------------
    always_comb begin
        if (accept) begin
            p1_fwd_next = wr_en && (p2_ch_reg == s_data.channel);
        end else begin
            p1_fwd_next = p1_fwd_reg || (wr_en && (p2_ch_reg == p1_ch_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_fwd_reg   <= 1'b0;
        end else begin
            p1_fwd_reg <= p1_fwd_next;
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_ch_reg   <= s_data.channel;
            p1_inr_reg  <= s_in_range;
            p1_live_reg <= live_reg[rd_addr];
            p1_gx1_reg  <= $signed({1'b0, gain_one_reg}) * $signed(s_data.sample_in);
            p1_gx2_reg  <= $signed({1'b0, gain_two_reg}) * $signed(s_data.sample_in);
        end
    end

    // Take the racing write first, then memory, else the cleared value
    always_comb begin
        priority if (p1_fwd_reg) begin
            p1_int1 = byp_int1_reg;
            p1_int2 = byp_int2_reg;
        end else if (p1_live_reg) begin
            p1_int1 = rd_data_reg[2*STATE_W-1:STATE_W];
            p1_int2 = rd_data_reg[STATE_W-1:0];
        end else begin
            p1_int1 = '0;
            p1_int2 = '0;
        end
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            p2_valid_reg <= 1'b1;
        end else if (out_ready) begin
            p2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            p2_ch_reg   <= p1_ch_reg;
            p2_inr_reg  <= p1_inr_reg;
            p2_int1_reg <= p1_int1;
            p2_int2_reg <= p1_int2;
            p2_gx1_reg  <= p1_gx1_reg;
            p2_gx2_reg  <= p1_gx2_reg;
            p2_g1i2_reg <= $signed({1'b0, gain_one_reg}) * p1_int2;
            p2_d1i1_reg <= $signed({1'b0, damp_one_reg}) * p1_int1;
            p2_g2i2_reg <= $signed({1'b0, gain_two_reg}) * p1_int2;
            p2_g1i1_reg <= $signed({1'b0, gain_one_reg}) * p1_int1;
        end
    end

    // g*(x - s2) split as g*x - g*s2; round half up, then floor
    assign sum1 = SUM_W'(p2_gx1_reg) - SUM_W'(p2_g1i2_reg) - SUM_W'(p2_d1i1_reg) + ROUND_HALF;
    assign sum2 = SUM_W'(p2_gx2_reg) - SUM_W'(p2_g2i2_reg) + SUM_W'(p2_g1i1_reg) + ROUND_HALF;
    assign t1   = $signed(sum1[SUM_W-1:COEF_W]);
    assign t2   = $signed(sum2[SUM_W-1:COEF_W]);

    assign acc1   = ACC_W'(p2_int1_reg) + (ACC_W'(t1) <<< 1);
    assign acc2   = ACC_W'(p2_int2_reg) + (ACC_W'(t2) <<< 1);
    assign bp_acc = ACC_W'(p2_int1_reg) + ACC_W'(t1);

    assign new_int1 = sat_state(acc1);
    assign new_int2 = sat_state(acc2);

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && p2_valid_reg) begin
            m_data_reg.channel_out  <= p2_ch_reg;
            m_data_reg.bandpass_out <= p2_inr_reg ? sat_out(bp_acc) : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> tb/tb_svf_bandpass_filter.sv
// Self-checking testbench for the state variable bandpass filter.
`timescale 1ns / 1ps

module tb_svf_bandpass_filter;
    import svf_pkg::*;

    localparam int REG_COUNT     = 3;
    localparam int REG_STRIDE    = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int RAMP_PHASE    = 5;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIR_ROWS      = 29;

    localparam logic [PADDR_W-1:0] ADDR_GAIN_ONE = PADDR_W'(REG_STRIDE * int'(REG_GAIN_ONE));
    localparam logic [PADDR_W-1:0] ADDR_DAMP_ONE = PADDR_W'(REG_STRIDE * int'(REG_DAMP_ONE));
    localparam logic [PADDR_W-1:0] ADDR_GAIN_TWO = PADDR_W'(REG_STRIDE * int'(REG_GAIN_TWO));
    localparam logic [PADDR_W-1:0] ADDR_SPARE    = PADDR_W'(REG_STRIDE * REG_COUNT);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [COEF_W-1:0]          COEF_MAX   = '1;

    localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;
    localparam longint ACC_MAX = (longint'(1) <<< (STATE_W - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    typedef struct {
        bit                   is_write;
        logic [PADDR_W-1:0]   addr;
        logic [PDATA_W-1:0]   wdata;
        svf_in_t              beat;
        bit                   pinned;
        svf_out_t             want;
    } dir_row_t;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    svf_in_t              s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    svf_out_t             m_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Filter state as the block should hold it.
    logic [COEF_W-1:0]          coef_shadow [REG_COUNT];
    logic signed [STATE_W-1:0]  band_acc [2];
    logic signed [STATE_W-1:0]  low_acc [2];
    svf_out_t                   bandpass_due [$];

    // Typed-in expectation travelling with the beat on the input channel.
    bit          pinned_en  = 1'b0;
    svf_out_t    pinned_out = '0;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int          holds_asked = 0;
    int          holds_done  = 0;
    int          hold_left   = 0;
    int          fault_count = 0;
    int unsigned cycle_count = 0;

    dir_row_t    directed [DIR_ROWS];

    svf_bandpass_filter uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint round_q24(input longint v);
        return (v + (longint'(1) <<< (COEF_W - 1))) >>> COEF_W;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // One trapezoidal SVF update on the beat's channel; returns the bandpass beat.
    function automatic svf_out_t predict_bandpass(input svf_in_t beat);
        longint   g1, d1, g2, x, s1, s2, t0, t1, t2;
        svf_out_t res;
        g1 = longint'(coef_shadow[REG_GAIN_ONE]);
        d1 = longint'(coef_shadow[REG_DAMP_ONE]);
        g2 = longint'(coef_shadow[REG_GAIN_TWO]);
        x  = longint'($signed(beat.sample_in));
        s1 = longint'(band_acc[beat.channel]);
        s2 = longint'(low_acc[beat.channel]);
        t0 = x - s2;
        t1 = round_q24(g1 * t0 - d1 * s1);
        t2 = round_q24(g2 * t0 + g1 * s1);
        res.channel_out  = beat.channel;
        res.bandpass_out = SAMPLE_W'(clamp(t1 + s1, OUT_MIN, OUT_MAX));
        band_acc[beat.channel] = STATE_W'(clamp(s1 + 2 * t1, ACC_MIN, ACC_MAX));
        low_acc[beat.channel]  = STATE_W'(clamp(s2 + 2 * t2, ACC_MIN, ACC_MAX));
        return res;
    endfunction

    always @(posedge aclk) begin : take_beat
        svf_out_t predicted;
        if (aresetn && s_valid && s_ready) begin
            // Advance the state even when the row carries its own expectation.
            predicted = predict_bandpass(s_data);
            bandpass_due.push_back(pinned_en ? pinned_out : predicted);
        end
    end

    always @(posedge aclk) begin : check_beat
        svf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (bandpass_due.size() == 0) begin
                $error("unexpected result beat: channel_out %0d bandpass_out %0d",
                       m_data.channel_out, $signed(m_data.bandpass_out));
                fault_count++;
            end else begin
                want = bandpass_due.pop_front();
                if (m_data.channel_out !== want.channel_out) begin
                    $error("channel_out: expected %0d, got %0d",
                           want.channel_out, m_data.channel_out);
                    fault_count++;
                end
                if (m_data.bandpass_out !== want.bandpass_out) begin
                    $error("bandpass_out: expected %0d, got %0d",
                           $signed(want.bandpass_out), $signed(m_data.bandpass_out));
                    fault_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_beat(input svf_in_t beat, input bit pin, input svf_out_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_data     <= beat;
        pinned_en  <= pin;
        pinned_out <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait for every pending result, then let the pipeline empty.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bandpass_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        int idx;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        idx = int'(addr) / REG_STRIDE;
        if (idx < REG_COUNT) coef_shadow[idx] = data[COEF_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_coefs();
        logic [PDATA_W-1:0] rd;
        for (int i = 0; i < REG_COUNT; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= PADDR_W'(REG_STRIDE * i);
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            rd = prdata;
            if (rd[COEF_W-1:0] !== coef_shadow[i]) begin
                $error("prdata: expected %0d, got %0d", coef_shadow[i], rd[COEF_W-1:0]);
                fault_count++;
            end
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic dir_row_t row_beat(input logic ch, input logic signed [SAMPLE_W-1:0] smp);
        dir_row_t r;
        r.is_write         = 1'b0;
        r.addr             = '0;
        r.wdata            = '0;
        r.beat.channel     = ch;
        r.beat.sample_in   = smp;
        r.pinned           = 1'b0;
        r.want             = '0;
        return r;
    endfunction

    function automatic dir_row_t row_pinned(input logic ch, input logic signed [SAMPLE_W-1:0] smp,
                                            input logic signed [SAMPLE_W-1:0] bp);
        dir_row_t r;
        r                    = row_beat(ch, smp);
        r.pinned             = 1'b1;
        r.want.channel_out   = ch;
        r.want.bandpass_out  = bp;
        return r;
    endfunction

    function automatic dir_row_t row_write(input logic [PADDR_W-1:0] addr,
                                           input logic [PDATA_W-1:0] data);
        dir_row_t r;
        r          = row_beat(1'b0, '0);
        r.is_write = 1'b1;
        r.addr     = addr;
        r.wdata    = data;
        return r;
    endfunction

    initial begin
        svf_in_t             beat;
        logic [COEF_W-1:0]   c_g1, c_d1, c_g2;
        int                  n_items;

        coef_shadow[REG_GAIN_ONE] = GAIN_ONE_RST;
        coef_shadow[REG_DAMP_ONE] = DAMP_ONE_RST;
        coef_shadow[REG_GAIN_TWO] = GAIN_TWO_RST;
        band_acc = '{default: '0};
        low_acc  = '{default: '0};
        beat     = '0;

        directed = '{
            // Zero in from reset state gives zero out.
            row_pinned(1'b0, '0, '0),
            row_pinned(1'b1, '0, '0),
            row_beat(1'b0, SAMPLE_MAX),
            row_beat(1'b0, SAMPLE_MIN),
            row_beat(1'b1, SAMPLE_MIN),
            row_beat(1'b1, SAMPLE_MAX),
            row_beat(1'b0, SAMPLE_W'(-1)),
            row_beat(1'b1, SAMPLE_W'(1)),
            row_write(ADDR_GAIN_ONE, '0),
            row_write(ADDR_DAMP_ONE, '0),
            row_write(ADDR_GAIN_TWO, '0),
            row_beat(1'b0, SAMPLE_MAX),
            row_beat(1'b1, SAMPLE_MIN),
            row_write(ADDR_GAIN_ONE, 32'h00FF_FFFF),
            row_write(ADDR_DAMP_ONE, 32'h00FF_FFFF),
            row_write(ADDR_GAIN_TWO, 32'h00FF_FFFF),
            row_beat(1'b0, SAMPLE_MAX),
            row_beat(1'b0, SAMPLE_MAX),
            row_beat(1'b1, SAMPLE_MIN),
            row_beat(1'b1, SAMPLE_MIN),
            row_beat(1'b0, '0),
            row_beat(1'b1, '0),
            // Write past the register map: must leave the coefficients alone.
            row_write(ADDR_SPARE, '0),
            row_beat(1'b0, SAMPLE_MIN),
            row_beat(1'b1, SAMPLE_MAX),
            // Upper data bits are not part of the coefficient.
            row_write(ADDR_GAIN_ONE, 32'hFFC0_0000),
            row_beat(1'b0, SAMPLE_MAX),
            row_beat(1'b1, 24'h555555),
            row_beat(1'b0, 24'hAAAAAA)
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].is_write) begin
                settle();
                reg_write(directed[i].addr, directed[i].wdata);
                check_coefs();
            end else begin
                send_beat(directed[i].beat, directed[i].pinned, directed[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: begin
                    c_g1 = GAIN_ONE_RST; c_d1 = DAMP_ONE_RST; c_g2 = GAIN_TWO_RST;
                end
                2: begin
                    c_g1 = COEF_MAX; c_d1 = COEF_MAX; c_g2 = COEF_MAX;
                end
                3, 7: begin
                    // Mostly stable settings: small gains, heavy damping.
                    c_g1 = COEF_W'($urandom_range(1 << 22));
                    c_d1 = COEF_W'($urandom_range(int'(COEF_MAX), 1 << 22));
                    c_g2 = COEF_W'($urandom_range(1 << 21));
                end
                4: begin
                    c_g1 = '0; c_d1 = '0; c_g2 = '0;
                end
                RAMP_PHASE: begin
                    // Undamped: constant input drives both integrators into their rails.
                    c_g1 = COEF_MAX; c_d1 = '0; c_g2 = '0;
                end
                default: begin
                    c_g1 = COEF_W'($urandom()); c_d1 = COEF_W'($urandom());
                    c_g2 = COEF_W'($urandom());
                end
            endcase
            reg_write(ADDR_GAIN_ONE, {8'($urandom()), c_g1});
            reg_write(ADDR_DAMP_ONE, {8'($urandom()), c_d1});
            reg_write(ADDR_GAIN_TWO, {8'($urandom()), c_g2});
            check_coefs();

            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
                default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            // Hold the receiver off while beats keep coming, so the input backs up.
            if (p == 0) holds_asked++;

            n_items = (p == RAMP_PHASE) ? 300 : 190;
            for (int n = 0; n < n_items; n++) begin
                // Favor repeats on one channel to exercise back-to-back state updates.
                if ($urandom_range(1) == 0) beat.channel = 1'($urandom());
                if (p == RAMP_PHASE && $urandom_range(7) != 0) begin
                    beat.sample_in = beat.channel ? SAMPLE_MIN : SAMPLE_MAX;
                end else begin
                    case ($urandom_range(7))
                        0: beat.sample_in = SAMPLE_MAX;
                        1: beat.sample_in = SAMPLE_MIN;
                        2: beat.sample_in = SAMPLE_W'(int'($urandom_range(512)) - 256);
                        default: beat.sample_in = SAMPLE_W'($urandom());
                    endcase
                end
                send_beat(beat, 1'b0, '0);
            end
        end

        settle();
        if (fault_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
design/svf_pkg.sv
design/svf_bandpass_filter.sv
tb/tb_svf_bandpass_filter.sv
